FILE: hdl/drm_pkg.sv
// Shared types, constants and coordinate helpers for the dirty rectangle merge table.
package drm_pkg;

  // Table and coordinate geometry
  localparam int TABLE_DEPTH = 32;
  localparam int COORD_BITS  = 15;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the request and result channels
  localparam int POS_W = 14;
  localparam int EXT_W = 13;
  localparam int OUT_W = 15;
  localparam int SUM_W = POS_W + 2;

  // Working widths for saturation and output truncation
  localparam int SAT_W  = ((SUM_W > COORD_BITS) ? SUM_W : COORD_BITS) + 1;
  localparam int OEXT_W = (COORD_BITS > OUT_W) ? COORD_BITS : OUT_W;

  localparam int COORD_HI_I = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_LO_I = -COORD_HI_I - 1;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(COORD_HI_I);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(COORD_LO_I);

  // Full-screen extent, saturated to the coordinate range
  localparam int FULL_EXT_I = (10000 > COORD_HI_I) ? COORD_HI_I : 10000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]      ocoord_t;
  typedef logic [CNT_W-1:0]             count_t;

  localparam coord_t FULL_EXT = COORD_BITS'(FULL_EXT_I);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_DRAIN = 2'd2
  } func_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } rect_t;

  // Search token walking down the cell row
  typedef struct packed {
    logic  valid;
    rect_t rect;
  } probe_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic occupied;
    logic tail;
    logic shift;
  } cell_ctrl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic done;
    logic merged;
  } cell_stat_t;

  // Clamp a sum to the signed coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SAT_W-1:0] ve;
    ve = SAT_W'(v);
    if (ve > SAT_HI) begin
      ve = SAT_HI;
    end else if (ve < SAT_LO) begin
      ve = SAT_LO;
    end
    return ve[COORD_BITS-1:0];
  endfunction

  // Keep the low bits of a coordinate for the result port
  function automatic ocoord_t to_out(input coord_t c);
    logic signed [OEXT_W-1:0] ce;
    ce = OEXT_W'(c);
    return ce[OUT_W-1:0];
  endfunction

endpackage

FILE: hdl/dirty_rect_merge_table.sv
// Top level: request sequencer, result register and the row of table cells.
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_ready   func, rect_x/y/w/h, force_full
//   out_      result     out_valid / out_ready accepted, merged, x1/y1/x2/y2, last
//
// An add sends the probe down the row one cell per cycle until the first touching
// entry or the tail slot; the result is then posted from S_RESP once the output is free.
// Clear, unused codes and a full-screen drain post a single result, via S_RESP or S_FULL.
// A drain of n entries gives one result per cycle while out_ready is high.
// Synchronous reset empties the table; entries are not cleared, only the count.
// New requests are taken only when the sequencer is idle; a held result stalls it.
module dirty_rect_merge_table
  import drm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic signed [POS_W-1:0]     in_rect_x,
  input  logic signed [POS_W-1:0]     in_rect_y,
  input  logic [EXT_W-1:0]            in_rect_w,
  input  logic [EXT_W-1:0]            in_rect_h,
  input  logic                        in_force_full,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic                        out_merged,
  output ocoord_t                     out_x1,
  output ocoord_t                     out_y1,
  output ocoord_t                     out_x2,
  output ocoord_t                     out_y2,
  output logic                        out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESP,
    S_FULL,
    S_DRAIN
  } state_t;

  state_t     state_r, state_nxt;
  count_t     count_r, count_nxt;
  logic       res_acc_r, res_acc_nxt;
  logic       res_mrg_r, res_mrg_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_acc_r, out_acc_nxt;
  logic       out_mrg_r, out_mrg_nxt;
  logic       out_last_r, out_last_nxt;
  ocoord_t    out_x1_r, out_x1_nxt;
  ocoord_t    out_y1_r, out_y1_nxt;
  ocoord_t    out_x2_r, out_x2_nxt;
  ocoord_t    out_y2_r, out_y2_nxt;

  logic       accept;
  logic       out_free;
  logic       table_full;
  logic       launch;
  logic       shift;
  logic       any_done;
  logic       any_merged;
  rect_t      new_rect;
  func_t      func;

  probe_t     probe_c [TABLE_DEPTH+1];
  rect_t      entry_c [TABLE_DEPTH];
  cell_ctrl_t ctrl_c  [TABLE_DEPTH];
  cell_stat_t stat_c  [TABLE_DEPTH];

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign func       = func_t'(in_func);
  assign shift      = (state_r == S_DRAIN) && out_free;
  assign launch     = accept && (func == FUNC_ADD) && !table_full;

  // Corners of the new rectangle, saturated
  assign new_rect.x1 = sat_coord(SUM_W'(in_rect_x));
  assign new_rect.y1 = sat_coord(SUM_W'(in_rect_y));
  assign new_rect.x2 = sat_coord(SUM_W'(in_rect_x) + SUM_W'($signed({1'b0, in_rect_w})));
  assign new_rect.y2 = sat_coord(SUM_W'(in_rect_y) + SUM_W'($signed({1'b0, in_rect_h})));

  assign probe_c[0].valid = launch;
  assign probe_c[0].rect  = new_rect;

  // Row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign ctrl_c[i].occupied = (CNT_W'(i) < count_r);
    assign ctrl_c[i].tail     = (CNT_W'(i) == count_r);
    assign ctrl_c[i].shift    = shift;

    rect_t next_e;
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign next_e = entry_c[i];
    end else begin : g_mid
      assign next_e = entry_c[i+1];
    end

    drm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl_c[i]),
      .probe_in   (probe_c[i]),
      .probe_out  (probe_c[i+1]),
      .next_entry (next_e),
      .entry      (entry_c[i]),
      .stat       (stat_c[i])
    );
  end

  // Collect the one cell that finished the search
  always_comb begin
    any_done   = 1'b0;
    any_merged = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_done   = any_done | stat_c[i].done;
      any_merged = any_merged | stat_c[i].merged;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_acc_nxt   = res_acc_r;
    res_mrg_nxt   = res_mrg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_acc_nxt   = out_acc_r;
    out_mrg_nxt   = out_mrg_r;
    out_last_nxt  = out_last_r;
    out_x1_nxt    = out_x1_r;
    out_y1_nxt    = out_y1_r;
    out_x2_nxt    = out_x2_r;
    out_y2_nxt    = out_y2_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_acc_nxt = 1'b1;
          res_mrg_nxt = 1'b0;
          unique case (func)
            FUNC_ADD: begin
              if (table_full) begin
                res_acc_nxt = 1'b0;
                state_nxt   = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            FUNC_DRAIN: begin
              if ((count_r == '0) || in_force_full) begin
                state_nxt = S_FULL;
              end else begin
                state_nxt = S_DRAIN;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (any_done) begin
          res_mrg_nxt = any_merged;
          if (!any_merged) count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_mrg_nxt   = res_mrg_r;
          out_last_nxt  = 1'b1;
          out_x1_nxt    = '0;
          out_y1_nxt    = '0;
          out_x2_nxt    = '0;
          out_y2_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_FULL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          out_mrg_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          out_x1_nxt    = '0;
          out_y1_nxt    = '0;
          out_x2_nxt    = to_out(FULL_EXT);
          out_y2_nxt    = to_out(FULL_EXT);
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_DRAIN: begin
        // Head cell goes out, the row shifts up by one
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b1;
          out_mrg_nxt   = 1'b0;
          out_last_nxt  = (count_r == CNT_W'(1));
          out_x1_nxt    = to_out(entry_c[0].x1);
          out_y1_nxt    = to_out(entry_c[0].y1);
          out_x2_nxt    = to_out(entry_c[0].x2);
          out_y2_nxt    = to_out(entry_c[0].y2);
          count_nxt     = count_r - 1'b1;
          if (count_r == CNT_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_acc_r  <= res_acc_nxt;
    res_mrg_r  <= res_mrg_nxt;
    out_acc_r  <= out_acc_nxt;
    out_mrg_r  <= out_mrg_nxt;
    out_last_r <= out_last_nxt;
    out_x1_r   <= out_x1_nxt;
    out_y1_r   <= out_y1_nxt;
    out_x2_r   <= out_x2_nxt;
    out_y2_r   <= out_y2_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_merged   = out_mrg_r;
  assign out_last     = out_last_r;
  assign out_x1       = out_x1_r;
  assign out_y1       = out_y1_r;
  assign out_x2       = out_x2_r;
  assign out_y2       = out_y2_r;

endmodule

FILE: hdl/drm_cell.sv
// One table cell: holds a rectangle, tests the passing probe, shifts toward the head on drain.
module drm_cell
  import drm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  probe_t     probe_in,
  output probe_t     probe_out,
  input  rect_t      next_entry,
  output rect_t      entry,
  output cell_stat_t stat
);

  logic   probe_v_r;
  rect_t  probe_rect_r;
  rect_t  entry_r;
  rect_t  entry_nxt;
  logic   overlap;
  logic   hit;
  logic   store;

  // Inclusive-edge touch test against the stored rectangle
  assign overlap = ctrl.occupied &&
                   (entry_r.x2 >= probe_rect_r.x1) && (entry_r.x1 <= probe_rect_r.x2) &&
                   (entry_r.y2 >= probe_rect_r.y1) && (entry_r.y1 <= probe_rect_r.y2);

  assign hit   = probe_v_r && overlap;
  assign store = probe_v_r && ctrl.tail && !overlap;

  // Probe moves on when this cell neither merged nor took it
  assign probe_out.valid = probe_v_r && !hit && !store;
  assign probe_out.rect  = probe_rect_r;

  assign stat.done   = hit || store;
  assign stat.merged = hit;
  assign entry       = entry_r;

  // Grow into the bounding box, append, or shift
  always_comb begin
    entry_nxt = entry_r;
    priority if (hit) begin
      if (probe_rect_r.x1 < entry_r.x1) entry_nxt.x1 = probe_rect_r.x1;
      if (probe_rect_r.y1 < entry_r.y1) entry_nxt.y1 = probe_rect_r.y1;
      if (probe_rect_r.x2 > entry_r.x2) entry_nxt.x2 = probe_rect_r.x2;
      if (probe_rect_r.y2 > entry_r.y2) entry_nxt.y2 = probe_rect_r.y2;
    end else if (store) begin
      entry_nxt = probe_rect_r;
    end else if (ctrl.shift) begin
      entry_nxt = next_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_v_r <= 1'b0;
    end else begin
      probe_v_r <= probe_in.valid;
    end
    probe_rect_r <= probe_in.rect;
    entry_r      <= entry_nxt;
  end

endmodule

FILE: test/drm_checker.sv
// Result checker for the dirty rectangle merge table: predicts every request and compares results.
module drm_checker
  import drm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic signed [POS_W-1:0] in_rect_x,
  input  logic signed [POS_W-1:0] in_rect_y,
  input  logic [EXT_W-1:0]        in_rect_w,
  input  logic [EXT_W-1:0]        in_rect_h,
  input  logic                    in_force_full,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_accepted,
  input  logic                    out_merged,
  input  ocoord_t                 out_x1,
  input  ocoord_t                 out_y1,
  input  ocoord_t                 out_x2,
  input  ocoord_t                 out_y2,
  input  logic                    out_last,
  output int                      fail_count,
  output int                      outstanding,
  output int                      merge_count,
  output int                      refuse_count,
  output int                      drained_count,
  output int                      full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCREEN  = 10000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic    accepted;
    logic    merged;
    ocoord_t x1;
    ocoord_t y1;
    ocoord_t x2;
    ocoord_t y2;
    logic    last;
  } drm_result_t;

  // Expected results in order, and the predicted table contents
  drm_result_t result_q[$];
  rect_t       dirty_rects[TABLE_DEPTH];
  int          dirty_count;
  int          errs;
  int          merges;
  int          refusals;
  int          drained;
  int          fulls;

  // Clamp to the signed coordinate range
  function automatic coord_t clamp_coord(int v);
    int hi;
    int lo;
    hi = (1 << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return coord_t'(v);
  endfunction

  function automatic drm_result_t status_result(logic acc, logic mrg);
    drm_result_t r;
    r = '0;
    r.accepted = acc;
    r.merged   = mrg;
    r.last     = 1'b1;
    return r;
  endfunction

  function automatic drm_result_t rect_result(rect_t b, logic is_last);
    drm_result_t r;
    r = '0;
    r.accepted = 1'b1;
    r.x1       = ocoord_t'(b.x1);
    r.y1       = ocoord_t'(b.y1);
    r.x2       = ocoord_t'(b.x2);
    r.y2       = ocoord_t'(b.y2);
    r.last     = is_last;
    return r;
  endfunction

  // Add: refuse when the table is full, else grow the first touching entry, else append
  task merge_or_append();
    rect_t nb;
    logic  hit;
    nb.x1 = clamp_coord(int'(in_rect_x));
    nb.y1 = clamp_coord(int'(in_rect_y));
    nb.x2 = clamp_coord(int'(in_rect_x) + int'(in_rect_w));
    nb.y2 = clamp_coord(int'(in_rect_y) + int'(in_rect_h));
    if (dirty_count >= TABLE_DEPTH) begin
      result_q.push_back(status_result(1'b0, 1'b0));
      refusals++;
      return;
    end
    hit = 1'b0;
    for (int i = 0; i < dirty_count && !hit; i++) begin
      if (dirty_rects[i].x2 >= nb.x1 && dirty_rects[i].x1 <= nb.x2 &&
          dirty_rects[i].y2 >= nb.y1 && dirty_rects[i].y1 <= nb.y2) begin
        if (nb.x1 < dirty_rects[i].x1) dirty_rects[i].x1 = nb.x1;
        if (nb.x2 > dirty_rects[i].x2) dirty_rects[i].x2 = nb.x2;
        if (nb.y1 < dirty_rects[i].y1) dirty_rects[i].y1 = nb.y1;
        if (nb.y2 > dirty_rects[i].y2) dirty_rects[i].y2 = nb.y2;
        hit = 1'b1;
      end
    end
    if (hit) begin
      merges++;
    end else begin
      dirty_rects[dirty_count] = nb;
      dirty_count++;
    end
    result_q.push_back(status_result(1'b1, hit));
  endtask

  // Drain: the stored run, or one full-screen rectangle when empty or forced
  task drain_rects();
    rect_t full;
    if (dirty_count == 0 || in_force_full) begin
      full.x1 = '0;
      full.y1 = '0;
      full.x2 = clamp_coord(FULL_SCREEN);
      full.y2 = clamp_coord(FULL_SCREEN);
      result_q.push_back(rect_result(full, 1'b1));
      fulls++;
    end else begin
      for (int i = 0; i < dirty_count; i++) begin
        result_q.push_back(rect_result(dirty_rects[i], i == dirty_count - 1));
      end
      drained += dirty_count;
    end
    dirty_count = 0;
  endtask

  task predict_request();
    case (in_func)
      FUNC_ADD:   merge_or_append();
      FUNC_CLEAR: begin
        dirty_count = 0;
        result_q.push_back(status_result(1'b1, 1'b0));
      end
      FUNC_DRAIN: drain_rects();
      default:    result_q.push_back(status_result(1'b1, 1'b0));
    endcase
  endtask

  task compare_result();
    drm_result_t got;
    drm_result_t want;
    got.accepted = out_accepted;
    got.merged   = out_merged;
    got.x1       = out_x1;
    got.y1       = out_y1;
    got.x2       = out_x2;
    got.y2       = out_y2;
    got.last     = out_last;
    if (result_q.size() == 0) begin
      errs++;
      if (errs <= REPORT_LIMIT) begin
        $display("%0t ERROR: result with none pending: acc=%0b mrg=%0b (%0d,%0d)-(%0d,%0d) last=%0b",
                 $realtime, got.accepted, got.merged, got.x1, got.y1, got.x2, got.y2, got.last);
      end
      return;
    end
    want = result_q.pop_front();
    if (got.accepted !== want.accepted || got.merged !== want.merged ||
        got.x1 !== want.x1 || got.y1 !== want.y1 || got.x2 !== want.x2 ||
        got.y2 !== want.y2 || got.last !== want.last) begin
      errs++;
      if (errs <= REPORT_LIMIT) begin
        $display("%0t ERROR: wanted acc=%0b mrg=%0b (%0d,%0d)-(%0d,%0d) last=%0b",
                 $realtime, want.accepted, want.merged, want.x1, want.y1, want.x2, want.y2,
                 want.last);
        $display("          got    acc=%0b mrg=%0b (%0d,%0d)-(%0d,%0d) last=%0b",
                 got.accepted, got.merged, got.x1, got.y1, got.x2, got.y2, got.last);
      end
    end
  endtask

  // Requests are predicted before results are compared in the same cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      dirty_count = 0;
      result_q.delete();
    end else begin
      if (in_valid && in_ready) predict_request();
      if (out_valid && out_ready) compare_result();
    end
    fail_count    <= errs;
    outstanding   <= result_q.size();
    merge_count   <= merges;
    refuse_count  <= refusals;
    drained_count <= drained;
    full_count    <= fulls;
  end

endmodule

FILE: test/tb_dirty_rect_merge_table.sv
// Testbench top for the dirty rectangle merge table: clock, reset, request stimulus and verdict.
module tb_dirty_rect_merge_table
  import drm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int REQ_TARGET  = 450;
  localparam int QUIET_AFTER = 400;
  localparam int PRESSURE_AT = 200;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 60;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_func       = FUNC_ADD;
  logic signed [POS_W-1:0] in_rect_x     = '0;
  logic signed [POS_W-1:0] in_rect_y     = '0;
  logic [EXT_W-1:0]        in_rect_w     = '0;
  logic [EXT_W-1:0]        in_rect_h     = '0;
  logic                    in_force_full = 1'b0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic                    out_accepted;
  logic                    out_merged;
  ocoord_t                 out_x1;
  ocoord_t                 out_y1;
  ocoord_t                 out_x2;
  ocoord_t                 out_y2;
  logic                    out_last;

  int fail_count;
  int outstanding;
  int merge_count;
  int refuse_count;
  int drained_count;
  int full_count;

  int req_count     = 0;
  bit quiet         = 1'b0;
  bit hold_req      = 1'b0;
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  dirty_rect_merge_table i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_rect_x    (in_rect_x),
    .in_rect_y    (in_rect_y),
    .in_rect_w    (in_rect_w),
    .in_rect_h    (in_rect_h),
    .in_force_full(in_force_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_merged   (out_merged),
    .out_x1       (out_x1),
    .out_y1       (out_y1),
    .out_x2       (out_x2),
    .out_y2       (out_y2),
    .out_last     (out_last)
  );

  drm_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_rect_x    (in_rect_x),
    .in_rect_y    (in_rect_y),
    .in_rect_w    (in_rect_w),
    .in_rect_h    (in_rect_h),
    .in_force_full(in_force_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_merged   (out_merged),
    .out_x1       (out_x1),
    .out_y1       (out_y1),
    .out_x2       (out_x2),
    .out_y2       (out_y2),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .merge_count  (merge_count),
    .refuse_count (refuse_count),
    .drained_count(drained_count),
    .full_count   (full_count)
  );

  // Result side: short random stalls, and one long hold-off on request
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int rnd_pos();
    return int'($urandom_range(0, 16383)) - 8192;
  endfunction

  function automatic int rnd_ext();
    return int'($urandom_range(0, 8191));
  endfunction

  // Hold a request until it is taken; valid stays high for the caller
  task automatic offer(logic [1:0] f, int x, int y, int w, int h, logic ff);
    in_valid      <= 1'b1;
    in_func       <= f;
    in_rect_x     <= POS_W'(x);
    in_rect_y     <= POS_W'(y);
    in_rect_w     <= EXT_W'(w);
    in_rect_h     <= EXT_W'(h);
    in_force_full <= ff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req_count++;
  endtask

  // Request with an optional idle burst in front
  task automatic send(logic [1:0] f, int x, int y, int w, int h, logic ff);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    offer(f, x, y, w, h, ff);
  endtask

  task automatic send_add(int x, int y, int w, int h);
    send(FUNC_ADD, x, y, w, h, 1'($urandom_range(0, 1)));
  endtask

  // Stop offering until every pending result is out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Close a sequence with a clear, a forced drain or a normal drain
  task automatic close_table();
    case ($urandom_range(0, 5))
      0:       send(FUNC_CLEAR, rnd_pos(), rnd_pos(), rnd_ext(), rnd_ext(),
                    1'($urandom_range(0, 1)));
      1:       send(FUNC_DRAIN, rnd_pos(), rnd_pos(), rnd_ext(), rnd_ext(), 1'b1);
      default: send(FUNC_DRAIN, rnd_pos(), rnd_pos(), rnd_ext(), rnd_ext(), 1'b0);
    endcase
  endtask

  // Small rectangles packed in one area, so many of them merge
  task automatic cluster_seq();
    int k;
    int area;
    int bx;
    int by;
    k    = $urandom_range(1, 12);
    area = $urandom_range(20, 3000);
    bx   = int'($urandom_range(0, 12000)) - 8192;
    by   = int'($urandom_range(0, 12000)) - 8192;
    repeat (k) begin
      send_add(bx + int'($urandom_range(0, area)), by + int'($urandom_range(0, area)),
               $urandom_range(0, area / 4), $urandom_range(0, area / 4));
    end
    close_table();
  endtask

  // Disjoint grid cells: 30 to 36 adds against a table of 32, so it can fill and run past it
  task automatic grid_seq();
    int k;
    int bx;
    int by;
    k  = $urandom_range(30, 36);
    bx = int'($urandom_range(0, 9000)) - 8192;
    by = int'($urandom_range(0, 9000)) - 8192;
    for (int i = 0; i < k; i++) begin
      send_add(bx + (i % 8) * 100 + int'($urandom_range(0, 40)),
               by + (i / 8) * 100 + int'($urandom_range(0, 40)),
               $urandom_range(0, 40), $urandom_range(0, 40));
    end
    close_table();
  endtask

  // Any operation, unused code included, with full-range fields
  task automatic noise_seq();
    logic [1:0] f;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 7))
        0:       f = FUNC_CLEAR;
        1:       f = FUNC_DRAIN;
        2:       f = FUNC_UNUSED;
        default: f = FUNC_ADD;
      endcase
      send(f, rnd_pos(), rnd_pos(), rnd_ext(), rnd_ext(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, unused code, field extremes, edge touch, forced drain
    send(FUNC_DRAIN, 0, 0, 0, 0, 1'b0);
    send(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
    send(FUNC_UNUSED, -8192, 8191, 8191, 0, 1'b1);
    send(FUNC_ADD, -8192, -8192, 0, 0, 1'b0);
    send(FUNC_ADD, 8191, 8191, 8191, 8191, 1'b1);
    send(FUNC_ADD, -8192, 8191, 8191, 0, 1'b0);
    send(FUNC_ADD, 0, 0, 10, 10, 1'b0);
    send(FUNC_ADD, 10, 10, 5, 5, 1'b0);     // corner touch grows the previous entry
    send(FUNC_ADD, 16, 0, 4, 4, 1'b0);      // one pixel clear of it: appended
    send(FUNC_ADD, 5, -20, 2, 30, 1'b0);
    send(FUNC_DRAIN, 0, 0, 0, 0, 1'b0);
    send(FUNC_ADD, 100, 100, 0, 0, 1'b0);
    send(FUNC_ADD, 1000, 1000, 8191, 8191, 1'b0);
    send(FUNC_DRAIN, 8191, -8192, 8191, 8191, 1'b1);
    send(FUNC_ADD, -300, -300, 50, 50, 1'b0);
    send(FUNC_ADD, -249, -249, 0, 0, 1'b0);
    send(FUNC_DRAIN, 0, 0, 0, 0, 1'b0);
    send(FUNC_ADD, 7, 7, 7, 7, 1'b0);
    send(FUNC_CLEAR, -1, -1, 8191, 8191, 1'b1);
    send(FUNC_DRAIN, 0, 0, 0, 0, 1'b0);

    // Random sequences, with one grid sequence up front
    grid_seq();
    while (req_count < REQ_TARGET) begin
      if (req_count >= QUIET_AFTER) quiet = 1'b1;
      if (!pressure_done && req_count >= PRESSURE_AT) begin
        // Results held back while requests keep coming
        pressure_done = 1'b1;
        wait_idle();
        hold_req = 1'b1;
        repeat (8) offer(FUNC_ADD, rnd_pos(), rnd_pos(), rnd_ext(), rnd_ext(), 1'b0);
        wait_idle();
      end
      case ($urandom_range(0, 9))
        5:       grid_seq();
        6, 7:    noise_seq();
        8:       if (!quiet) wait_idle();
        default: cluster_seq();
      endcase
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests: %0d merges, %0d adds refused by a full table,",
             req_count, merge_count, refuse_count);
    $display("%0d stored rectangles drained, %0d full-screen drains.",
             drained_count, full_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/drm_pkg.sv
hdl/drm_cell.sv
hdl/dirty_rect_merge_table.sv
test/drm_checker.sv
test/tb_dirty_rect_merge_table.sv
